>>> design/error_record_table_search_defines.svh
// Assertion macros shared by the error record table search block.
// Included by the modules that carry concurrent checks; needs nothing else.
`ifndef ERROR_RECORD_TABLE_SEARCH_DEFINES_SVH
`define ERROR_RECORD_TABLE_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define ERTS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ERTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/erts_pkg.sv
// Shared types and constants for the error record table search block.
// Used by the controller, the datapath and the top level; depends on nothing.
package erts_pkg;

    // Defaults and fixed field widths
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int CFG_W           = 11;
    localparam int IDXOUT_W        = 10;
    localparam int TALLY_W         = 16;

    localparam logic [CFG_W-1:0]   MAX_ENTRIES_RST = 11'd1024;
    localparam logic [TALLY_W-1:0] TALLY_MAX       = 16'hFFFF;

    // Request codes
    typedef logic [1:0] req_t;
    localparam req_t REQ_CLEAR = 2'd0;
    localparam req_t REQ_ADD   = 2'd1;
    localparam req_t REQ_PROBE = 2'd2;
    localparam req_t REQ_RSVD  = 2'd3;  // reserved, no effect

    // Input word
    typedef struct packed {
        req_t        req_type;
        logic [31:0] addr;
        logic [31:0] data_word;
        logic [31:0] ref_word;
        logic        last_probe;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic                accepted;
        logic                found;
        logic [IDXOUT_W-1:0] found_index;
        logic [TALLY_W-1:0]  missing_count;
        logic                compare_done;
    } out_word_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;       // latch the accepted input word
        logic exec_simple;   // run clear / add / reserved request
        logic probe_init;    // open search range over the table
        logic search_issue;  // first table read at the range midpoint
        logic search_step;   // narrow range and read the next midpoint
        logic probe_finish;  // write probe result and update tally
        logic probe_hit;     // qualifier for probe_finish
        logic out_load;      // move result into the output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        req_t req_type;
        logic range_nonempty;
        logic hit;
        logic next_nonempty;
        logic out_free;
    } sts_t;

endpackage

>>> design/erts_ctrl.sv
// Sequencer for the error record table search block.
// Uses erts_pkg for command and status types; drives the datapath.
`include "error_record_table_search_defines.svh"

module erts_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  erts_pkg::sts_t sts,
    output erts_pkg::cmd_t cmd
);
    import erts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_START,
        S_CMP,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.req_type == REQ_PROBE)
                begin
                    cmd.probe_init = 1'b1;
                    state_next     = S_START;
                end
                else
                begin
                    cmd.exec_simple = 1'b1;
                    state_next      = S_DONE;
                end
            end
            S_START:
            begin
                if (sts.range_nonempty)
                begin
                    cmd.search_issue = 1'b1;
                    state_next       = S_CMP;
                end
                else
                begin
                    cmd.probe_finish = 1'b1;
                    state_next       = S_DONE;
                end
            end
            S_CMP:
            begin
                if (sts.hit)
                begin
                    cmd.probe_finish = 1'b1;
                    cmd.probe_hit    = 1'b1;
                    state_next       = S_DONE;
                end
                else
                begin
                    cmd.search_step = 1'b1;
                    if (!sts.next_nonempty)
                    begin
                        cmd.probe_finish = 1'b1;
                        state_next       = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Compare phase is only entered from the range check or itself
    `ERTS_ASSERT_IMPL(a_cmp_entry, clk, rst_n, state_reg == S_CMP, $past(state_reg) == S_START || $past(state_reg) == S_CMP, "compare state entered from wrong state")

endmodule

>>> design/erts_dpath.sv
// Datapath of the error record table search block: record memory,
// search range registers, tally, config register and output register.
// Uses erts_pkg types; controlled by erts_ctrl.
`include "error_record_table_search_defines.svh"

module erts_dpath #(
    parameter int TABLE_DEPTH = erts_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  erts_pkg::in_word_t            in_word,
    input  logic                          cfg_we,
    input  logic [erts_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          out_stall,
    output logic                          out_valid,
    output erts_pkg::out_word_t           out_word,
    input  erts_pkg::cmd_t                cmd,
    output erts_pkg::sts_t                sts
);
    import erts_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] data_word;
        logic [31:0] ref_word;
    } rec_t;

    rec_t rec_mem [TABLE_DEPTH];
    rec_t rd_reg;

    in_word_t            req_reg;
    logic [CFG_W-1:0]    max_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [TALLY_W-1:0]  tally_reg;
    logic [TALLY_W-1:0]  tally_next;
    logic [CNT_W-1:0]    lo_reg;
    logic [CNT_W-1:0]    hi_reg;
    logic [CNT_W-1:0]    lo_next;
    logic [CNT_W-1:0]    hi_next;
    logic [IDX_W-1:0]    mid_reg;
    logic [IDX_W-1:0]    mid_cur;
    logic [IDX_W-1:0]    mid_next;
    logic [CNT_W:0]      sum_cur;
    logic [CNT_W:0]      sum_next;
    logic [LIM_W-1:0]    limit;
    logic                add_ok;
    logic                mem_rd;
    logic [IDX_W-1:0]    rd_idx;
    logic [TALLY_W-1:0]  shown;
    out_word_t           res_reg;
    out_word_t           res_next;
    out_word_t           out_reg;
    logic                out_valid_reg;

    // Add limit: smaller of the register and the table depth
    always_comb
    begin
        if (LIM_W'(max_reg) < LIM_W'(TABLE_DEPTH))
        begin
            limit = LIM_W'(max_reg);
        end
        else
        begin
            limit = LIM_W'(TABLE_DEPTH);
        end
    end
    assign add_ok = (LIM_W'(cnt_reg) < limit);

    // Midpoints of the current and the narrowed range
    assign sum_cur = {1'b0, lo_reg} + {1'b0, hi_reg} - (CNT_W+1)'(1);
    assign mid_cur = sum_cur[IDX_W:1];

    always_comb
    begin
        if (rd_reg.addr < req_reg.addr)
        begin
            lo_next = CNT_W'(mid_reg) + CNT_W'(1);
            hi_next = hi_reg;
        end
        else
        begin
            lo_next = lo_reg;
            hi_next = CNT_W'(mid_reg);
        end
    end
    assign sum_next = {1'b0, lo_next} + {1'b0, hi_next} - (CNT_W+1)'(1);
    assign mid_next = sum_next[IDX_W:1];

    assign mem_rd = cmd.search_issue | cmd.search_step;
    assign rd_idx = cmd.search_step ? mid_next : mid_cur;

    // Status back to the sequencer
    assign sts.req_type       = req_reg.req_type;
    assign sts.range_nonempty = (lo_reg < hi_reg);
    assign sts.hit            = (rd_reg.addr == req_reg.addr);
    assign sts.next_nonempty  = (lo_next < hi_next);
    assign sts.out_free       = !out_valid_reg || !out_stall;

    // Tally after this probe, saturating on a miss; cleared when it is the last probe
    always_comb
    begin
        if (!cmd.probe_hit && (tally_reg != TALLY_MAX))
        begin
            shown = tally_reg + TALLY_W'(1);
        end
        else
        begin
            shown = tally_reg;
        end
        tally_next = req_reg.last_probe ? '0 : shown;
    end

    // Result word for the request being finished
    always_comb
    begin
        res_next               = '0;
        res_next.missing_count = tally_reg;
        if (cmd.probe_finish)
        begin
            res_next.found         = cmd.probe_hit;
            res_next.found_index   = cmd.probe_hit ? IDXOUT_W'(mid_reg) : '0;
            res_next.missing_count = shown;
            res_next.compare_done  = req_reg.last_probe;
        end
        else if ((req_reg.req_type == REQ_ADD) && add_ok)
        begin
            res_next.accepted = 1'b1;
        end
    end

    // Record memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.exec_simple && (req_reg.req_type == REQ_ADD) && add_ok)
        begin
            rec_mem[cnt_reg[IDX_W-1:0]] <= '{addr:      req_reg.addr,
                                             data_word: req_reg.data_word,
                                             ref_word:  req_reg.ref_word};
        end
        if (mem_rd)
        begin
            rd_reg <= rec_mem[rd_idx];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= in_word;
        end
        if (cmd.probe_init)
        begin
            lo_reg <= '0;
            hi_reg <= cnt_reg;
        end
        else if (cmd.search_step)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
        if (mem_rd)
        begin
            mid_reg <= rd_idx;
        end
        if (cmd.exec_simple || cmd.probe_finish)
        begin
            res_reg <= res_next;
        end
        if (cmd.out_load)
        begin
            out_reg <= res_reg;
        end
    end

    // Control state: config, count, tally, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg       <= MAX_ENTRIES_RST;
            cnt_reg       <= '0;
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_reg <= cfg_wdata;
            end
            if (cmd.exec_simple && (req_reg.req_type == REQ_CLEAR))
            begin
                cnt_reg <= '0;
            end
            else if (cmd.exec_simple && (req_reg.req_type == REQ_ADD) && add_ok)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.probe_finish)
            begin
                tally_reg <= tally_next;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    // Record count never runs past the table
    `ERTS_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(TABLE_DEPTH), "record count exceeds table depth")
    // An accepted add grows the count by exactly one
    `ERTS_ASSERT_NEXT(a_add_grow, clk, rst_n, cmd.exec_simple && (req_reg.req_type == REQ_ADD) && add_ok, cnt_reg == $past(cnt_reg) + CNT_W'(1), "add did not advance record count")
    // Last probe of a run leaves the tally cleared
    `ERTS_ASSERT_NEXT(a_tally_clr, clk, rst_n, cmd.probe_finish && req_reg.last_probe, tally_reg == '0, "tally not cleared after last probe")

endmodule

>>> design/error_record_table_search.sv
// Error record table search: clear, add (ascending address) and binary-search probe.
// Path from accept to result word valid: clear/add via S_EXEC then S_DONE; probe via S_EXEC,
// S_START, S_CMP once per table read, then S_DONE, with at most log2(depth)+1 reads.
// One word at a time, taken the cycle after the previous result is loaded;
// a stalled output holds off the next word.
// Reset (rst_n, async low): table empty, tally zero, max_entries 1024, no result pending.
module error_record_table_search #(
    parameter int TABLE_DEPTH = erts_pkg::TABLE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  erts_pkg::in_word_t         in_word,
    output logic                       out_valid,
    input  logic                       out_stall,
    output erts_pkg::out_word_t        out_word,
    input  logic                       cfg_we,
    input  logic [erts_pkg::CFG_W-1:0] cfg_wdata
);
    import erts_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer
    erts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Table, search and result datapath
    erts_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_word  (out_word),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
